@@ design/nsr_pkg.sv @@
// ----------------------------------------------------------------------------
// nsr_pkg
// shared types and constants for the newton square root iteration block
// ----------------------------------------------------------------------------
`default_nettype none

package nsr_pkg;

	localparam int unsigned ITER_CAP   = 64;
	localparam int unsigned ITER_W     = 7;
	localparam int unsigned DATA_W     = 32;
	localparam int unsigned FRAC_W     = 16;
	localparam int unsigned DVD_W      = DATA_W + FRAC_W;
	localparam int unsigned SQ_W       = 46;
	localparam int unsigned RES_W      = 47;
	localparam int unsigned PROD_W     = 2 * DATA_W;
	localparam int unsigned DIV_STEPS  = DVD_W;
	localparam int unsigned DIV_CNT_W  = $clog2(DIV_STEPS);
	localparam int unsigned CFG_IDX_W  = 1;
	localparam int unsigned OUT_TDATA_W = 160;

	localparam logic [CFG_IDX_W-1:0] REG_TOLERANCE = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_ITER  = 1'b1;

	localparam logic [DATA_W-1:0] Q_ONE         = 32'h0001_0000;
	localparam logic [DATA_W-1:0] TOL_RESET     = 32'd66;
	localparam logic [ITER_W-1:0] MAX_ITER_RESET = 7'd20;
	localparam logic [ITER_W-1:0] ITER_CAP_V    = 7'd64;
	localparam logic [SQ_W-1:0]   SQ_MAX        = {SQ_W{1'b1}};

	typedef struct packed {
		logic busy;
		logic done;
	} nsr_div_stat_t;

endpackage

`default_nettype wire

@@ design/nsr_div.sv @@
// ----------------------------------------------------------------------------
// nsr_div
// restoring divider, one quotient bit per cycle, 48 by 32 bits
// ----------------------------------------------------------------------------
`default_nettype none

module nsr_div (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       start,
	input  wire logic [nsr_pkg::DVD_W-1:0]  dividend,
	input  wire logic [nsr_pkg::DATA_W-1:0] divisor,
	output nsr_pkg::nsr_div_stat_t          stat,
	output logic [nsr_pkg::DVD_W-1:0]       quotient
);
	import nsr_pkg::*;

	logic [DVD_W-1:0]     quo_q;
	logic [DATA_W-1:0]    rem_q;
	logic [DATA_W-1:0]    dsr_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 busy_q;
	logic                 done_q;

	logic [DATA_W:0]   rem_sh;
	logic [DATA_W+1:0] diff;
	logic              ge;

	assign rem_sh = {rem_q, quo_q[DVD_W-1]};
	assign diff   = {1'b0, rem_sh} - {2'b00, dsr_q};
	assign ge     = ~diff[DATA_W+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == DIV_CNT_W'(DIV_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dsr_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[DVD_W-2:0], ge};
			rem_q <= ge ? diff[DATA_W-1:0] : rem_sh[DATA_W-1:0];
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign quotient  = quo_q;

	a_done_after_busy : assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(busy_q))
		else $error("divider done without a running division");

	a_cnt_bound : assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> cnt_q < DIV_CNT_W'(DIV_STEPS))
		else $error("divider step count out of range");

	a_one_done : assert property (@(posedge clk) disable iff (!arst_n)
		done_q |=> !done_q)
		else $error("divider done held for more than one cycle");

endmodule

`default_nettype wire

@@ design/newton_square_root_iteration_top.sv @@
// ----------------------------------------------------------------------------
// newton_square_root_iteration_top
// heron square root steps in q16.16, one result row per step
// ----------------------------------------------------------------------------
// one step runs: divider start, one divider step per bit of the 48-bit quotient,
// quotient return, then sum, multiply, square saturate and row output; a step
// whose estimate is zero skips the divider. an item gives up to 64 rows, and
// the block takes one item at a time. arst_n clears control and loads
// tolerance 66 and max_iterations 20.
`default_nettype none

module newton_square_root_iteration_top (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_wen,
	input  wire logic [nsr_pkg::CFG_IDX_W-1:0]   cfg_addr,
	input  wire logic [nsr_pkg::DATA_W-1:0]      cfg_wdata,
	input  wire logic                            s_axis_tvalid,
	output logic                                 s_axis_tready,
	input  wire logic [nsr_pkg::DATA_W-1:0]      s_axis_tdata,  // radicand
	output logic                                 m_axis_tvalid,
	input  wire logic                            m_axis_tready,
	// prior_estimate, next_estimate, estimate_squared, residual, converged, zero pad
	output logic [nsr_pkg::OUT_TDATA_W-1:0]      m_axis_tdata,
	output logic                                 m_axis_tlast
);
	import nsr_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV,
		ST_SUM,
		ST_MUL,
		ST_SQ,
		ST_OUT
	} state_t;

	state_t state_q;

	logic [DATA_W-1:0] tol_q;
	logic [ITER_W-1:0] max_iter_q;
	logic [ITER_W-1:0] limit_q;
	logic [ITER_W-1:0] iter_q;
	logic              div_start_q;

	logic [DATA_W-1:0] n_q;
	logic [DATA_W-1:0] old_q;
	logic [DVD_W-1:0]  quo_q;
	logic [DATA_W-1:0] nxt_q;
	logic [PROD_W-1:0] prod_q;
	logic [SQ_W-1:0]   sq_q;

	nsr_div_stat_t     div_stat;
	logic [DVD_W-1:0]  div_quo;

	logic              in_xfer;
	logic              out_load;
	logic [ITER_W-1:0] limit_in;
	logic [DVD_W:0]    sum;
	logic [DATA_W-1:0] nxt_sat;
	logic [SQ_W-1:0]   n_ext;
	logic              neg;
	logic [SQ_W-1:0]   mag;
	logic [RES_W-1:0]  res;
	logic              conv;
	logic              fin;

	nsr_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start_q),
		.dividend ({n_q, {FRAC_W{1'b0}}}),
		.divisor  (old_q),
		.stat     (div_stat),
		.quotient (div_quo)
	);

	assign s_axis_tready = (state_q == ST_IDLE);
	assign in_xfer       = s_axis_tvalid && s_axis_tready;
	assign out_load      = (state_q == ST_OUT) && (!m_axis_tvalid || m_axis_tready);
	assign limit_in      = (max_iter_q > ITER_CAP_V) ? ITER_CAP_V : max_iter_q;

	assign sum     = {{(DVD_W-DATA_W+1){1'b0}}, old_q} + {1'b0, quo_q};
	assign nxt_sat = (|sum[DVD_W:DATA_W+1]) ? {DATA_W{1'b1}} : sum[DATA_W:1];

	assign n_ext = {{(SQ_W-DATA_W){1'b0}}, n_q};
	assign neg   = sq_q > n_ext;
	assign mag   = neg ? (sq_q - n_ext) : (n_ext - sq_q);
	assign res   = {1'b0, n_ext} - {1'b0, sq_q};
	assign conv  = mag < {{(SQ_W-DATA_W){1'b0}}, tol_q};
	assign fin   = conv || (iter_q == limit_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			tol_q         <= TOL_RESET;
			max_iter_q    <= MAX_ITER_RESET;
			limit_q       <= '0;
			iter_q        <= '0;
			div_start_q   <= 1'b0;
			m_axis_tvalid <= 1'b0;
			m_axis_tlast  <= 1'b0;
			m_axis_tdata  <= '0;
		end else begin
			div_start_q <= 1'b0;
			if (cfg_wen) begin
				case (cfg_addr)
					REG_TOLERANCE: tol_q      <= cfg_wdata;
					REG_MAX_ITER:  max_iter_q <= cfg_wdata[ITER_W-1:0];
					default:       ;
				endcase
			end
			if (m_axis_tvalid && m_axis_tready && !out_load)
				m_axis_tvalid <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (in_xfer) begin
						limit_q <= limit_in;
						iter_q  <= ITER_W'(1);
						if (limit_in != '0) begin
							div_start_q <= 1'b1;
							state_q     <= ST_DIV;
						end
					end
				end
				ST_DIV: begin
					if (div_stat.done)
						state_q <= ST_SUM;
				end
				ST_SUM: state_q <= ST_MUL;
				ST_MUL: state_q <= ST_SQ;
				ST_SQ:  state_q <= ST_OUT;
				ST_OUT: begin
					if (out_load) begin
						m_axis_tvalid <= 1'b1;
						m_axis_tlast  <= fin;
						m_axis_tdata  <= {2'b00, conv, res, sq_q, nxt_q, old_q};
						if (fin) begin
							state_q <= ST_IDLE;
						end else begin
							iter_q <= iter_q + 1'b1;
							if (nxt_q != '0) begin
								div_start_q <= 1'b1;
								state_q     <= ST_DIV;
							end else begin
								state_q <= ST_SUM;
							end
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			n_q   <= s_axis_tdata;
			old_q <= Q_ONE;
		end
		if (state_q == ST_DIV && div_stat.done)
			quo_q <= div_quo;
		if (state_q == ST_SUM)
			nxt_q <= nxt_sat;
		if (state_q == ST_MUL)
			prod_q <= nxt_q * nxt_q;
		if (state_q == ST_SQ)
			sq_q <= (|prod_q[PROD_W-1:SQ_W+FRAC_W]) ? SQ_MAX : prod_q[SQ_W+FRAC_W-1:FRAC_W];
		if (out_load && !fin) begin
			old_q <= nxt_q;
			if (nxt_q == '0)
				quo_q <= '0;
		end
	end

	a_ready_not_dividing : assert property (@(posedge clk) disable iff (!arst_n)
		div_stat.busy |-> !s_axis_tready)
		else $error("input ready while a division runs");

	a_iter_bound : assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> (iter_q != '0) && (iter_q <= limit_q))
		else $error("step count outside the run limit");

	a_limit_cap : assert property (@(posedge clk) disable iff (!arst_n)
		limit_q <= ITER_CAP_V)
		else $error("run limit above cap");

	a_conv_last : assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tdata[SQ_W+RES_W+2*DATA_W]) |-> m_axis_tlast)
		else $error("converged row not marked last");

	a_div_done_in_div : assert property (@(posedge clk) disable iff (!arst_n)
		div_stat.done |-> (state_q == ST_DIV))
		else $error("quotient returned outside the divide state");

endmodule

`default_nettype wire

@@ tb/sv/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// stream-level test of the newton square root iteration block: every
// accepted radicand is expanded into its expected heron step rows by a
// local q16.16 predictor, and every output transfer is checked field by
// field against the oldest pending row. tolerance and iteration limit are
// changed between phases while the block is drained, both stream sides
// stall at random, and one long output hold-off backs the block up.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;

	timeunit 1ns;
	timeprecision 1ps;

	import nsr_pkg::*;

	localparam int DRAIN_CYCLES = 120;
	localparam int PHASE_ITEMS  = 42;

	typedef struct packed {
		logic [31:0] prior;
		logic [31:0] nxt;
		logic [45:0] sq;
		logic [46:0] res;
		logic        conv;
		logic        fin;
	} root_row_t;

	class heron_row_board;
		root_row_t   rows[$];
		logic [31:0] tol_q16;
		logic [6:0]  iter_limit;
		int          mismatches;

		function new();
			tol_q16    = TOL_RESET;
			iter_limit = MAX_ITER_RESET;
			mismatches = 0;
		endfunction

		function int pending();
			return rows.size();
		endfunction

		task report_mismatch(input string msg);
			$display("mismatch at %0t: %s", $realtime, msg);
			mismatches++;
		endtask

		function void note_radicand(input logic [31:0] n);
			logic [63:0] n64, old, q, s, sq, mag, diff;
			int          limit;
			root_row_t   r;
			n64   = {32'b0, n};
			limit = (iter_limit > ITER_CAP_V) ? ITER_CAP : iter_limit;
			old   = {32'b0, Q_ONE};
			for (int i = 1; i <= limit; i++) begin
				// zero estimate gives a zero quotient
				q = (old != 0) ? ((n64 << 16) / old) : 64'd0;
				s = (old + q) >> 1;
				if (s > 64'hFFFF_FFFF)
					s = 64'hFFFF_FFFF;
				sq = (s * s) >> 16;
				if (sq > {18'b0, SQ_MAX})
					sq = {18'b0, SQ_MAX};
				mag    = (sq > n64) ? sq - n64 : n64 - sq;
				diff   = n64 - sq;
				r.prior = old[31:0];
				r.nxt   = s[31:0];
				r.sq    = sq[45:0];
				r.res   = diff[46:0];
				r.conv  = mag < {32'b0, tol_q16};
				r.fin   = r.conv || (i == limit);
				rows.push_back(r);
				if (r.conv)
					break;
				old = s;
			end
		endfunction

		task check_row(input logic [OUT_TDATA_W-1:0] td, input logic tl);
			root_row_t e;
			if (rows.size() == 0) begin
				report_mismatch($sformatf("row with nothing pending, tdata %h", td));
			end else begin
				e = rows.pop_front();
				if (td[31:0] !== e.prior)
					report_mismatch($sformatf("prior_estimate %h, want %h", td[31:0], e.prior));
				if (td[63:32] !== e.nxt)
					report_mismatch($sformatf("next_estimate %h, want %h", td[63:32], e.nxt));
				if (td[109:64] !== e.sq)
					report_mismatch($sformatf("estimate_squared %h, want %h", td[109:64], e.sq));
				if (td[156:110] !== e.res)
					report_mismatch($sformatf("residual %h, want %h", td[156:110], e.res));
				if (td[157] !== e.conv)
					report_mismatch($sformatf("converged %b, want %b", td[157], e.conv));
				if (td[159:158] !== 2'b00)
					report_mismatch($sformatf("pad bits %b not zero", td[159:158]));
				if (tl !== e.fin)
					report_mismatch($sformatf("tlast %b, want %b", tl, e.fin));
			end
		endtask
	endclass

	logic                     clk;
	logic                     arst_n;
	logic                     cfg_wen;
	logic [CFG_IDX_W-1:0]     cfg_addr;
	logic [DATA_W-1:0]        cfg_wdata;
	logic                     s_axis_tvalid;
	logic                     s_axis_tready;
	logic [DATA_W-1:0]        s_axis_tdata;
	logic                     m_axis_tvalid;
	logic                     m_axis_tready;
	logic [OUT_TDATA_W-1:0]   m_axis_tdata;
	logic                     m_axis_tlast;

	heron_row_board sb;
	bit             idle_on;
	int             hold_request;

	newton_square_root_iteration_top u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wen       (cfg_wen),
		.cfg_addr      (cfg_addr),
		.cfg_wdata     (cfg_wdata),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	function automatic logic [31:0] pick_radicand();
		logic [63:0] m;
		case ($urandom_range(0, 4))
			0: return $urandom;
			1: return $urandom >> $urandom_range(0, 31);
			2: begin
				m = $urandom_range(0, 32'h00FF_FFFF);
				return 32'((m * m) >> 16);
			end
			3: return 32'($urandom_range(0, 255));
			default: return ~($urandom >> $urandom_range(0, 31));
		endcase
	endfunction

	task automatic send_item(input logic [31:0] r);
		if (idle_on && $urandom_range(0, 3) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= r;
		do @(posedge clk); while (!s_axis_tready);
		sb.note_radicand(r);
	endtask

	task automatic settle_block();
		s_axis_tvalid <= 1'b0;
		while (sb.pending() > 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic set_config(input logic [31:0] tol, input logic [6:0] iters);
		settle_block();
		cfg_wen   <= 1'b1;
		cfg_addr  <= REG_TOLERANCE;
		cfg_wdata <= tol;
		@(posedge clk);
		cfg_addr  <= REG_MAX_ITER;
		cfg_wdata <= {25'b0, iters};
		@(posedge clk);
		cfg_wen   <= 1'b0;
		sb.tol_q16    = tol;
		sb.iter_limit = iters;
	endtask

	// output side: checks each transfer, then picks tready for the next cycle
	initial begin
		int burst_left;
		int hold_left;
		burst_left    = 0;
		hold_left     = 0;
		m_axis_tready <= 1'b0;
		forever begin
			@(posedge clk);
			if (m_axis_tvalid && m_axis_tready)
				sb.check_row(m_axis_tdata, m_axis_tlast);
			if (hold_request > 0) begin
				hold_left    = hold_request;
				hold_request = 0;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_axis_tready <= 1'b0;
			end else if (idle_on && burst_left > 0) begin
				burst_left--;
				m_axis_tready <= 1'b0;
			end else if (idle_on && $urandom_range(0, 5) == 0) begin
				burst_left = $urandom_range(1, 4) - 1;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	initial begin
		logic [31:0] tol_v;
		logic [6:0]  it_v;
		sb            = new();
		idle_on       = 1'b1;
		hold_request  = 0;
		arst_n        <= 1'b0;
		cfg_wen       <= 1'b0;
		cfg_addr      <= REG_TOLERANCE;
		cfg_wdata     <= '0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata  <= '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings, field extremes and simple roots
		send_item(32'h0000_0000);
		send_item(32'h0000_0001);
		send_item(32'h0000_0002);
		send_item(32'h0000_8000);
		send_item(32'h0001_0000);
		send_item(32'h0002_0000);
		send_item(32'h0004_0000);
		send_item(32'h5555_5555);
		send_item(32'hAAAA_AAAA);
		send_item(32'h7FFF_FFFF);
		send_item(32'h8000_0000);
		send_item(32'hFFFF_FFFF);

		// zero tolerance at full cap: estimate decays to zero, square saturates
		set_config(32'h0000_0000, 7'd64);
		send_item(32'h0000_0000);
		send_item(32'hFFFF_FFFF);

		// widest tolerance, single step
		set_config(32'hFFFF_FFFF, 7'd1);
		send_item(32'h1234_5678);
		send_item(32'h0000_0000);
		send_item(32'hFFFF_FFFF);

		// zero iteration limit: no rows
		set_config(32'd1000, 7'd0);
		send_item(32'h0001_0000);
		send_item(32'hFFFF_FFFF);

		// limit above cap
		set_config(32'h0000_0000, 7'd100);
		send_item(32'h0009_0000);

		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0: begin tol_v = $urandom_range(1, 200);     it_v = $urandom_range(1, 24); end
				1: begin tol_v = $urandom;                   it_v = $urandom_range(1, 64); end
				2: begin tol_v = $urandom_range(0, 2000);    it_v = $urandom_range(8, 20); end
				3: begin tol_v = 32'd0;                      it_v = $urandom_range(1, 6);  end
				4: begin tol_v = $urandom_range(1, 1 << 20); it_v = $urandom_range(1, 12); end
				default: begin
					tol_v = $urandom_range(1, 500);
					it_v  = $urandom_range(10, 40);
				end
			endcase
			set_config(tol_v, it_v);
			if (ph == 5)
				idle_on = 1'b0;
			for (int k = 0; k < PHASE_ITEMS; k++) begin
				if (ph == 2 && k == 5)
					hold_request = 600;
				send_item(pick_radicand());
			end
		end

		settle_block();
		repeat (200) @(posedge clk);
		if (sb.mismatches == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

	initial begin
		#60_000_000;
		$display("*** FAILED ***");
		$finish;
	end

endmodule

`default_nettype wire

@@ newton_square_root_iteration_top.f @@
design/nsr_pkg.sv
design/nsr_div.sv
design/newton_square_root_iteration_top.sv
tb/sv/tb_top.sv
